>>> hw/rtl/ebrm_pkg.sv
// Package for the expiring batch ring manager: types, codes and constants.
package ebrm_pkg;

	localparam int MAX_CHUNKS = 32;
	localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);

	localparam logic [31:0] LIFETIME_RST   = 32'd1000;
	localparam logic [15:0] BATCH_VERT_RST = 16'd1;
	localparam logic [7:0]  VERT_BYTES_RST = 8'd1;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LIFETIME     = 2'd0;
	localparam cfg_idx_t CFG_BATCH_VERTS  = 2'd1;
	localparam cfg_idx_t CFG_VERTEX_BYTES = 2'd2;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_COMMIT = 2'd1,
		OP_TICK   = 2'd2,
		OP_RSVD   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_CHUNK  = 2'd2,
		KIND_EMPTY  = 2'd3
	} kind_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [5:0]  slot_index;
		logic [31:0] time_value;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic        granted;
		logic [5:0]  granted_slot;
		logic [31:0] chunk_start_bytes;
		logic [21:0] chunk_vertices;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_CMP,
		ST_RUN,
		ST_MUL_SB,
		ST_MUL_NV,
		ST_MUL_SCALE,
		ST_EMIT,
		ST_FLUSH
	} state_t;

endpackage

>>> hw/rtl/ebrm_time_ram.sv
// Start-time memory: one write port, one read port with registered data.
module ebrm_time_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/ebrm_mul.sv
// Shared multiplier with a registered product.
module ebrm_mul #(
	parameter int AW = 23
) (
	input  logic             clk,
	input  logic [AW-1:0]    a,
	input  logic [15:0]      b,
	output logic [AW+15:0]   prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= (AW + 16)'(a) * (AW + 16)'(b);
	end

endmodule

>>> hw/rtl/expiring_batch_ring_manager_unit.sv
// Top level of the expiring batch ring manager: sequencer, slot state and config.
//
// Ring of NUM_SLOTS buffer batches, each with an active bit and a start time.
// A transaction is taken when start is high and busy is low. Allocate and
// commit reply on result the next cycle and busy stays low. A tick runs a
// sequencer while busy is high. Expiry reads each visited slot's start time
// from the start-time memory, then does the 33-bit compare; at most
// min(pending, NUM_SLOTS) slots are visited. If anything is still outstanding,
// the run scan walks the slots in order, and each chunk works out its start,
// vertex count and byte scaling on the single shared multiplier and is then
// emitted; a flush step ends the tick. Results come as one-cycle strobes
// on result_valid and cannot be held off; last marks the final result of a
// transaction. Reserved opcodes are taken and give nothing. Configuration
// writes are always accepted (cfg_ready is tied high) and are meant to happen
// while the block is idle. Slot state resets at once; there is no clearing
// pass.
module expiring_batch_ring_manager_unit #(
	parameter int NUM_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ebrm_pkg::cmd_t     cmd,
	output logic               result_valid,
	output ebrm_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  ebrm_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]        cfg_data
);
	import ebrm_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int AW = CW + 16;
	localparam int PW = AW + 16;

	// config registers
	logic [31:0] lifetime_q;
	logic [15:0] batch_verts_q;
	logic [7:0]  vertex_bytes_q;

	// ring state
	logic [NUM_SLOTS-1:0] active_q;
	logic [15:0]          head_q, tail_q;
	logic [SW-1:0]        head_slot_q, tail_slot_q;

	// tick sequencer state
	state_t                 state_q, state_d;
	logic [31:0]            now_q;
	logic [CW-1:0]          visits_q, vis_q;
	logic [15:0]            exp_cnt_q;
	logic [SW-1:0]          exp_slot_q;
	logic [CW-1:0]          scan_q, run_start_q, len_q;
	logic                   in_run_q;
	logic [CHUNK_CNT_W-1:0] n_q;
	logic [AW-1:0]          sb_q;
	logic [21:0]            nv_q;
	result_t                pend_q;
	logic                   pend_valid_q;
	result_t                result_q;
	logic                   result_valid_q;

	logic          accept;
	logic [15:0]   pending;
	logic          exp_act, scan_done, scan_act, expired;
	logic          commit_ok;
	logic          ram_re;
	logic [31:0]   ram_rdata;
	logic [AW-1:0] mul_a;
	logic [15:0]   mul_b;
	logic [PW-1:0] prod_q;
	logic [31:0]   sb_sat;
	logic [21:0]   nv_sat;

	// next slot of a 16-bit counter; the counter wraps to slot zero too
	function automatic logic [SW-1:0] slot_inc(input logic [15:0] cnt,
			input logic [SW-1:0] slot);
		logic [SW-1:0] r;
		if (cnt == 16'hFFFF || slot == SW'(NUM_SLOTS - 1)) begin
			r = '0;
		end else begin
			r = slot + SW'(1);
		end
		return r;
	endfunction

	// builds one whole result word
	function automatic result_t make_result(input kind_t k, input logic g,
			input logic [5:0] gslot, input logic [31:0] sb, input logic [21:0] nv,
			input logic lst);
		result_t r;
		r.kind              = k;
		r.granted           = g;
		r.granted_slot      = gslot;
		r.chunk_start_bytes = sb;
		r.chunk_vertices    = nv;
		r.last              = lst;
		return r;
	endfunction

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign pending   = tail_q - head_q;
	assign exp_act   = active_q[exp_slot_q];
	assign scan_done = (scan_q == CW'(NUM_SLOTS));
	assign scan_act  = !scan_done && active_q[scan_q[SW-1:0]];
	assign expired   = ({1'b0, ram_rdata} + {1'b0, lifetime_q}) < {1'b0, now_q};
	assign commit_ok = (32'(cmd.slot_index) < NUM_SLOTS);
	assign sb_sat    = (|prod_q[PW-1:32]) ? 32'hFFFF_FFFF : prod_q[31:0];
	assign nv_sat    = (|prod_q[PW-1:22]) ? 22'h3F_FFFF : prod_q[21:0];

	assign result_valid = result_valid_q;
	assign result       = result_q;

	ebrm_time_ram #(
		.DEPTH(NUM_SLOTS),
		.AW   (SW)
	) u_time_ram (
		.clk  (clk),
		.we   (accept && cmd.opcode == OP_COMMIT && commit_ok),
		.waddr(SW'(cmd.slot_index)),
		.wdata(cmd.time_value),
		.re   (ram_re),
		.raddr(exp_slot_q),
		.rdata(ram_rdata)
	);

	ebrm_mul #(
		.AW(AW)
	) u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	// sequencer: next state, memory read and multiplier operands
	always_comb begin
		state_d = state_q;
		ram_re  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd.opcode == OP_TICK) begin
					state_d = ST_EXP_RD;
				end
			end
			ST_EXP_RD: begin
				if (vis_q == visits_q || !exp_act) begin
					state_d = (head_q != tail_q) ? ST_RUN : ST_FLUSH;
				end else begin
					ram_re  = 1'b1;
					state_d = ST_EXP_CMP;
				end
			end
			ST_EXP_CMP: begin
				state_d = ST_EXP_RD;
			end
			ST_RUN: begin
				if (scan_done) begin
					state_d = in_run_q ? ST_MUL_SB : ST_FLUSH;
				end else if (!scan_act && in_run_q) begin
					state_d = ST_MUL_SB;
				end
			end
			ST_MUL_SB: begin
				mul_a   = AW'(run_start_q);
				mul_b   = batch_verts_q;
				state_d = ST_MUL_NV;
			end
			ST_MUL_NV: begin
				mul_a   = AW'(len_q);
				mul_b   = batch_verts_q;
				state_d = ST_MUL_SCALE;
			end
			ST_MUL_SCALE: begin
				mul_a   = sb_q;
				mul_b   = {8'd0, vertex_bytes_q};
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = (n_q == CHUNK_CNT_W'(MAX_CHUNKS - 1)) ? ST_FLUSH : ST_RUN;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q     <= LIFETIME_RST;
			batch_verts_q  <= BATCH_VERT_RST;
			vertex_bytes_q <= VERT_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LIFETIME:     lifetime_q     <= cfg_data;
				CFG_BATCH_VERTS:  batch_verts_q  <= cfg_data[15:0];
				CFG_VERTEX_BYTES: vertex_bytes_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// slot state, sequencer datapath and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			head_slot_q    <= '0;
			tail_slot_q    <= '0;
			now_q          <= '0;
			visits_q       <= '0;
			vis_q          <= '0;
			exp_cnt_q      <= '0;
			exp_slot_q     <= '0;
			scan_q         <= '0;
			run_start_q    <= '0;
			len_q          <= '0;
			in_run_q       <= 1'b0;
			n_q            <= '0;
			sb_q           <= '0;
			nv_q           <= '0;
			pend_q         <= '0;
			pend_valid_q   <= 1'b0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.opcode)
							OP_ALLOC: begin
								result_valid_q <= 1'b1;
								if (!active_q[tail_slot_q]) begin
									result_q    <= make_result(KIND_ALLOC, 1'b1,
										6'(tail_slot_q), '0, '0, 1'b1);
									tail_q      <= tail_q + 16'd1;
									tail_slot_q <= slot_inc(tail_q, tail_slot_q);
								end else begin
									result_q <= make_result(KIND_ALLOC, 1'b0, '0, '0,
										'0, 1'b1);
								end
							end
							OP_COMMIT: begin
								result_valid_q <= 1'b1;
								result_q       <= make_result(KIND_COMMIT, 1'b0, '0, '0,
									'0, 1'b1);
								if (commit_ok) begin
									active_q[SW'(cmd.slot_index)] <= 1'b1;
								end
							end
							OP_TICK: begin
								now_q        <= cmd.time_value;
								visits_q     <= (pending < 16'(NUM_SLOTS)) ?
									CW'(pending) : CW'(NUM_SLOTS);
								vis_q        <= '0;
								exp_cnt_q    <= head_q;
								exp_slot_q   <= head_slot_q;
								scan_q       <= '0;
								in_run_q     <= 1'b0;
								n_q          <= '0;
								pend_valid_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_EXP_CMP: begin
					if (expired) begin
						active_q[exp_slot_q] <= 1'b0;
						head_q      <= head_q + 16'd1;
						head_slot_q <= slot_inc(head_q, head_slot_q);
					end
					vis_q      <= vis_q + CW'(1);
					exp_cnt_q  <= exp_cnt_q + 16'd1;
					exp_slot_q <= slot_inc(exp_cnt_q, exp_slot_q);
				end
				ST_RUN: begin
					if (scan_done) begin
						if (in_run_q) begin
							len_q    <= scan_q - run_start_q;
							in_run_q <= 1'b0;
						end
					end else begin
						scan_q <= scan_q + CW'(1);
						if (scan_act && !in_run_q) begin
							in_run_q    <= 1'b1;
							run_start_q <= scan_q;
						end else if (!scan_act && in_run_q) begin
							len_q    <= scan_q - run_start_q;
							in_run_q <= 1'b0;
						end
					end
				end
				ST_MUL_NV: begin
					sb_q <= prod_q[AW-1:0];
				end
				ST_MUL_SCALE: begin
					nv_q <= nv_sat;
				end
				ST_EMIT: begin
					// previous chunk goes out now that another one follows it
					if (pend_valid_q) begin
						result_valid_q <= 1'b1;
						result_q       <= pend_q;
					end
					pend_q       <= make_result(KIND_CHUNK, 1'b0, '0, sb_sat, nv_q, 1'b0);
					pend_valid_q <= 1'b1;
					n_q          <= n_q + CHUNK_CNT_W'(1);
				end
				ST_FLUSH: begin
					result_valid_q <= 1'b1;
					if (pend_valid_q) begin
						result_q <= make_result(KIND_CHUNK, 1'b0, '0,
							pend_q.chunk_start_bytes, pend_q.chunk_vertices, 1'b1);
					end else begin
						result_q <= make_result(KIND_EMPTY, 1'b0, '0, '0, '0, 1'b1);
					end
					pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// a tick always holds the block busy for its sequence
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == OP_TICK) |=> busy)
		else $error("tick accepted without entering the sequence");

	// an empty chunk list is always the final result of its tick
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == KIND_EMPTY) |-> result.last)
		else $error("empty chunk list not marked last");

	// a result that is not last is a chunk with more of the tick still to run
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |-> (busy && result.kind == KIND_CHUNK))
		else $error("non-final result outside a chunk stream");

endmodule
